### rtl/assert_macros.svh
// assertion macros shared by the median window filter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define MWF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true outside reset
`define MWF_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

### rtl/mwf_pkg.sv
// shared types and constants of the median window filter
`default_nettype none

package mwf_pkg;

   localparam int unsigned MAX_WIDTH_DEF  = 1024;
   localparam int unsigned MAX_WINDOW_DEF = 7;

   localparam int unsigned PIX_W        = 8;
   localparam int unsigned ROW_W        = 16;
   localparam int unsigned WIDTH_REG_W  = 11;
   localparam int unsigned HEIGHT_REG_W = 16;
   localparam int unsigned WINDOW_REG_W = 3;
   localparam int unsigned CSR_DATA_W   = 16;
   localparam int unsigned CSR_IDX_W    = 2;

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd1024;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd1024;
   localparam logic [WINDOW_REG_W-1:0] WINDOW_RESET = 3'd3;

   localparam logic MODE_PIXEL = 1'b0;
   localparam logic MODE_DRAIN = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_WINDOW_SIZE  = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_FLUSH,
      ST_PICK,
      ST_LOAD
   } state_type;

   typedef struct packed {
      logic accept;
      logic win_init;
      logic scan_step;
      logic pick_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic res_ready;
      logic scan_last;
      logic pick_done;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

### rtl/mwf_ctrl.sv
// controller state machine of the median window filter
`default_nettype none

module mwf_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   input  mwf_pkg::status_type  status,
   output mwf_pkg::cmd_type     cmd
);

   mwf_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mwf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mwf_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = mwf_pkg::ST_CHECK;
         end
         mwf_pkg::ST_CHECK: begin
            state_in = status.res_ready ? mwf_pkg::ST_SCAN : mwf_pkg::ST_IDLE;
         end
         mwf_pkg::ST_SCAN: begin
            if (status.scan_last) state_in = mwf_pkg::ST_FLUSH;
         end
         mwf_pkg::ST_FLUSH: begin
            state_in = mwf_pkg::ST_PICK;
         end
         mwf_pkg::ST_PICK: begin
            if (status.pick_done) state_in = mwf_pkg::ST_LOAD;
         end
         mwf_pkg::ST_LOAD: begin
            if (status.out_free) state_in = mwf_pkg::ST_IDLE;
         end
         default: begin
            state_in = mwf_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         mwf_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         mwf_pkg::ST_CHECK: begin
            cmd.win_init = status.res_ready;
         end
         mwf_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
         end
         mwf_pkg::ST_FLUSH: begin
         end
         mwf_pkg::ST_PICK: begin
            cmd.pick_step = !status.pick_done;
         end
         mwf_pkg::ST_LOAD: begin
            cmd.load_out = status.out_free;
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

### rtl/mwf_dp.sv
// datapath: config registers, line store, window scan, sorting cells, output register
`default_nettype none

module mwf_dp #(
   parameter int unsigned MAX_WIDTH  = mwf_pkg::MAX_WIDTH_DEF,
   parameter int unsigned MAX_WINDOW = mwf_pkg::MAX_WINDOW_DEF
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               csr_we,
   input  wire  [mwf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  [mwf_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire                               req_tuser,
   input  wire  [mwf_pkg::PIX_W-1:0]         req_tdata,
   input  mwf_pkg::cmd_type                  cmd,
   output mwf_pkg::status_type               status,
   input  wire                               rsp_tready,
   output logic                              rsp_tvalid,
   output logic [mwf_pkg::PIX_W-1:0]         rsp_tdata,
   output logic                              rsp_tlast
);

   localparam int unsigned LINE_ROWS = MAX_WINDOW + 1;
   localparam int unsigned SW   = $clog2(LINE_ROWS);
   localparam int unsigned CW   = $clog2(MAX_WIDTH);
   localparam int unsigned WW   = $clog2(MAX_WIDTH + 1);
   localparam int unsigned XW   = (WW > mwf_pkg::WIDTH_REG_W) ? WW : mwf_pkg::WIDTH_REG_W;
   localparam int unsigned AW   = $clog2(MAX_WINDOW + 1);
   localparam int unsigned AXW  = (AW > mwf_pkg::WINDOW_REG_W) ? AW : mwf_pkg::WINDOW_REG_W;
   localparam int unsigned NCELL = MAX_WINDOW * MAX_WINDOW;
   localparam int unsigned NW   = $clog2(NCELL + 1);
   localparam int unsigned RW   = mwf_pkg::ROW_W;
   localparam int unsigned RSW  = RW + 2;
   localparam int unsigned CSW  = CW + 3;
   localparam int unsigned PW   = mwf_pkg::PIX_W;

   // config registers
   logic [mwf_pkg::WIDTH_REG_W-1:0]  width_ff;
   logic [mwf_pkg::HEIGHT_REG_W-1:0] height_ff;
   logic [mwf_pkg::WINDOW_REG_W-1:0] window_ff;
   logic                             cfg_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= mwf_pkg::WIDTH_RESET;
         height_ff <= mwf_pkg::HEIGHT_RESET;
         window_ff <= mwf_pkg::WINDOW_RESET;
      end else if (csr_we) begin
         case (mwf_pkg::csr_index_type'(csr_index))
            mwf_pkg::CSR_IMAGE_WIDTH: begin
               width_ff <= csr_wdata[mwf_pkg::WIDTH_REG_W-1:0];
            end
            mwf_pkg::CSR_IMAGE_HEIGHT: begin
               height_ff <= csr_wdata[mwf_pkg::HEIGHT_REG_W-1:0];
            end
            mwf_pkg::CSR_WINDOW_SIZE: begin
               window_ff <= csr_wdata[mwf_pkg::WINDOW_REG_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (mwf_pkg::csr_index_type'(csr_index))
         mwf_pkg::CSR_IMAGE_WIDTH, mwf_pkg::CSR_IMAGE_HEIGHT,
         mwf_pkg::CSR_WINDOW_SIZE: cfg_hit = csr_we;
         default: cfg_hit = 1'b0;
      endcase
   end

   // effective geometry with out-of-range values clamped
   logic [XW-1:0]  width_x;
   logic [WW-1:0]  eff_w;
   logic [RW-1:0]  eff_h;
   logic [AXW-1:0] window_x;
   logic [AW-1:0]  eff_a;
   logic [AW-1:0]  half;
   logic [AW-1:0]  dlow;

   always_comb begin
      width_x  = XW'(width_ff);
      window_x = AXW'(window_ff);
      if (width_x == '0) begin
         eff_w = WW'(1);
      end else if (width_x > XW'(MAX_WIDTH)) begin
         eff_w = WW'(MAX_WIDTH);
      end else begin
         eff_w = width_x[WW-1:0];
      end
      eff_h = (height_ff == '0) ? RW'(1) : height_ff;
      if (window_x == '0) begin
         eff_a = AW'(1);
      end else if (window_x > AXW'(MAX_WINDOW)) begin
         eff_a = AW'(MAX_WINDOW);
      end else begin
         eff_a = window_x[AW-1:0];
      end
      half = eff_a >> 1;
      dlow = eff_a - AW'(1) - half;
   end

   // raster position counters
   logic [RW-1:0] in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [CW-1:0] in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [SW-1:0] in_slot_ff, in_slot_in, out_slot_ff, out_slot_in;
   logic          pix_ok;
   logic          is_last;

   assign pix_ok  = (req_tuser == mwf_pkg::MODE_PIXEL) && (in_row_ff < eff_h);
   assign is_last = (out_row_ff == eff_h - RW'(1)) && (WW'(out_col_ff) == eff_w - WW'(1));

   always_comb begin
      in_row_in   = in_row_ff;
      in_col_in   = in_col_ff;
      in_slot_in  = in_slot_ff;
      out_row_in  = out_row_ff;
      out_col_in  = out_col_ff;
      out_slot_in = out_slot_ff;
      if (cmd.accept && pix_ok) begin
         if (WW'(in_col_ff) + WW'(1) >= eff_w) begin
            in_col_in  = '0;
            in_row_in  = in_row_ff + RW'(1);
            in_slot_in = (in_slot_ff == SW'(LINE_ROWS - 1)) ? '0 : in_slot_ff + SW'(1);
         end else begin
            in_col_in = in_col_ff + CW'(1);
         end
      end
      if (cmd.load_out) begin
         if (WW'(out_col_ff) + WW'(1) >= eff_w) begin
            out_col_in  = '0;
            out_row_in  = out_row_ff + RW'(1);
            out_slot_in = (out_slot_ff == SW'(LINE_ROWS - 1)) ? '0 : out_slot_ff + SW'(1);
         end else begin
            out_col_in = out_col_ff + CW'(1);
         end
      end
      // frame restart after the last result or any register write
      if ((cmd.load_out && is_last) || cfg_hit) begin
         in_row_in   = '0;
         in_col_in   = '0;
         in_slot_in  = '0;
         out_row_in  = '0;
         out_col_in  = '0;
         out_slot_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_row_ff   <= '0;
         in_col_ff   <= '0;
         in_slot_ff  <= '0;
         out_row_ff  <= '0;
         out_col_ff  <= '0;
         out_slot_ff <= '0;
      end else begin
         in_row_ff   <= in_row_in;
         in_col_ff   <= in_col_in;
         in_slot_ff  <= in_slot_in;
         out_row_ff  <= out_row_in;
         out_col_ff  <= out_col_in;
         out_slot_ff <= out_slot_in;
      end
   end

   // result ready once the bottom right in-bounds window pixel has arrived
   logic [RW:0]   row_need_x;
   logic [RW-1:0] row_need;
   logic [WW:0]   col_need_x;
   logic [WW-1:0] col_need;
   logic          res_ready;

   always_comb begin
      row_need_x = (RW + 1)'(out_row_ff) + (RW + 1)'(dlow);
      col_need_x = (WW + 1)'(out_col_ff) + (WW + 1)'(dlow);
      row_need   = (row_need_x > (RW + 1)'(eff_h - RW'(1))) ? eff_h - RW'(1)
                                                            : row_need_x[RW-1:0];
      col_need   = (col_need_x > (WW + 1)'(eff_w - WW'(1))) ? eff_w - WW'(1)
                                                            : col_need_x[WW-1:0];
      res_ready  = (out_row_ff < eff_h) && (WW'(out_col_ff) < eff_w) &&
                   ((in_row_ff > row_need) ||
                    ((in_row_ff == row_need) && (WW'(in_col_ff) > col_need)));
   end

   assign status.res_ready = res_ready;

   // window scan counters
   logic [AW-1:0]         win_m_ff, win_m_in, win_n_ff, win_n_in;
   logic signed [RSW-1:0] win_row_ff, win_row_in;
   logic signed [CSW-1:0] win_col_ff, win_col_in;
   logic signed [CSW-1:0] col_start;
   logic [SW-1:0]         win_slot_ff, win_slot_in;
   logic [SW:0]           slot_start_x;
   logic                  rd_ok;

   assign col_start = $signed(CSW'(out_col_ff)) - $signed(CSW'(half));
   assign rd_ok = (win_row_ff >= 0) && (win_row_ff < $signed(RSW'(eff_h))) &&
                  (win_col_ff >= 0) && (win_col_ff < $signed(CSW'(eff_w)));
   assign status.scan_last = (win_m_ff == eff_a - AW'(1)) && (win_n_ff == eff_a - AW'(1));

   always_comb begin
      win_m_in     = win_m_ff;
      win_n_in     = win_n_ff;
      win_row_in   = win_row_ff;
      win_col_in   = win_col_ff;
      win_slot_in  = win_slot_ff;
      slot_start_x = (SW + 1)'(out_slot_ff) + (SW + 1)'(LINE_ROWS) - (SW + 1)'(half);
      if (cmd.win_init) begin
         win_m_in   = '0;
         win_n_in   = '0;
         win_row_in = $signed(RSW'(out_row_ff)) - $signed(RSW'(half));
         win_col_in = col_start;
         if (slot_start_x >= (SW + 1)'(LINE_ROWS)) begin
            win_slot_in = SW'(slot_start_x - (SW + 1)'(LINE_ROWS));
         end else begin
            win_slot_in = slot_start_x[SW-1:0];
         end
      end else if (cmd.scan_step) begin
         if (win_n_ff == eff_a - AW'(1)) begin
            win_n_in    = '0;
            win_m_in    = win_m_ff + AW'(1);
            win_col_in  = col_start;
            win_row_in  = win_row_ff + RSW'(1);
            win_slot_in = (win_slot_ff == SW'(LINE_ROWS - 1)) ? '0
                                                               : win_slot_ff + SW'(1);
         end else begin
            win_n_in   = win_n_ff + AW'(1);
            win_col_in = win_col_ff + CSW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      win_m_ff    <= win_m_in;
      win_n_ff    <= win_n_in;
      win_row_ff  <= win_row_in;
      win_col_ff  <= win_col_in;
      win_slot_ff <= win_slot_in;
   end

   // line store, one row per slot
   logic [PW-1:0] line_mem [LINE_ROWS][MAX_WIDTH];
   logic [PW-1:0] rd_data_ff;
   logic          rd_vld_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept && pix_ok) begin
         line_mem[in_slot_ff][in_col_ff] <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_step && rd_ok) begin
         rd_data_ff <= line_mem[win_slot_ff][win_col_ff[CW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.scan_step && rd_ok;
      end
   end

   // insertion sort cells, then shift down to the median
   logic [PW-1:0]    sort_ff [NCELL];
   logic [PW-1:0]    sort_in [NCELL];
   logic [NCELL-1:0] gt;
   logic [NW-1:0]    cnt_ff, cnt_in, pick_ff, pick_in;

   always_comb begin
      for (int i = 0; i < NCELL; i++) begin
         gt[i] = (NW'(i) < cnt_ff) && (sort_ff[i] > rd_data_ff);
      end
   end

   always_comb begin
      for (int i = 0; i < NCELL; i++) begin
         sort_in[i] = sort_ff[i];
      end
      if (rd_vld_ff) begin
         if (gt[0] || (cnt_ff == '0)) sort_in[0] = rd_data_ff;
         for (int i = 1; i < NCELL; i++) begin
            if (gt[i]) begin
               sort_in[i] = gt[i-1] ? sort_ff[i-1] : rd_data_ff;
            end else if (NW'(i) == cnt_ff) begin
               sort_in[i] = gt[i-1] ? sort_ff[i-1] : rd_data_ff;
            end
         end
      end else if (cmd.pick_step) begin
         for (int i = 0; i < NCELL - 1; i++) begin
            sort_in[i] = sort_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NCELL; i++) begin
         sort_ff[i] <= sort_in[i];
      end
   end

   always_comb begin
      cnt_in  = cnt_ff;
      pick_in = pick_ff;
      if (cmd.win_init) begin
         cnt_in  = '0;
         pick_in = '0;
      end else begin
         if (rd_vld_ff) cnt_in = cnt_ff + NW'(1);
         if (cmd.pick_step) pick_in = pick_ff + NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         pick_ff <= '0;
      end else begin
         cnt_ff  <= cnt_in;
         pick_ff <= pick_in;
      end
   end

   assign status.pick_done = (pick_ff == (cnt_ff >> 1));

   // output register
   logic rsp_valid_ff;

   assign status.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_tdata <= sort_ff[0];
         rsp_tlast <= is_last;
      end
   end

endmodule

`default_nettype wire

### rtl/median_window_filter_unit.sv
// A 2-D median filter over 8-bit grey pixels in raster order. Each request transaction
// is a pixel (tuser low) or a drain tick (tuser high); after the last pixel, drain ticks
// push out the results still pending, and the result for the final pixel carries tlast.
// One transaction is handled at a time. An item that yields no result passes the check
// state and goes back to idle; an item that yields a result also passes the scan, flush,
// pick and load states, and waits in load while the previous result still waits
// on rsp_tready: the window is read from the single read port of the line store one
// pixel a cycle into a row of insertion-sort cells, then the sorted cells shift down to
// the median. The line store needs no clearing after reset.
`default_nettype none

`include "assert_macros.svh"

module median_window_filter_unit #(
   parameter int unsigned MAX_WIDTH  = mwf_pkg::MAX_WIDTH_DEF,
   parameter int unsigned MAX_WINDOW = mwf_pkg::MAX_WINDOW_DEF
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             csr_we,
   input  wire  [mwf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire  [mwf_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire                             req_tvalid,
   output logic                            req_tready,
   input  wire  [mwf_pkg::PIX_W-1:0]       req_tdata,   // [7:0] pixel
   input  wire                             req_tuser,   // [0] mode
   output logic                            rsp_tvalid,
   input  wire                             rsp_tready,
   output logic [mwf_pkg::PIX_W-1:0]       rsp_tdata,   // [7:0] filtered_pixel
   output logic                            rsp_tlast
);

   mwf_pkg::cmd_type    cmd;
   mwf_pkg::status_type status;

   mwf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mwf_dp #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_WINDOW (MAX_WINDOW)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // busy right after taking a transaction
   `MWF_ASSERT(a_busy_after_req, clock, reset, req_tvalid && req_tready |=> !req_tready, "request taken while busy")
   // a result is only loaded outside the idle state
   `MWF_ASSERT(a_load_not_idle, clock, reset, $rose(rsp_tvalid) |-> !$past(req_tready), "result loaded while idle")
   `MWF_NEVER(a_scan_exclusive, clock, reset, cmd.scan_step && (cmd.load_out || cmd.accept), "scan overlaps accept or load")

endmodule

`default_nettype wire

### dv/tb_median_window_filter_unit.sv
// self-checking testbench for the median window filter unit
`timescale 1ns / 100ps
`default_nettype none

module tb_median_window_filter_unit;

   localparam int MAXW = 1024;
   localparam int MAXA = 7;
   localparam int LROWS = MAXA + 1;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int ITEM_BUDGET = 1600;
   localparam int QUIET_TAIL = 1350;

   typedef struct packed {
      logic       mode;
      logic [7:0] pixel;
   } req_item_type;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } rsp_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [mwf_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [mwf_pkg::CSR_DATA_W-1:0] csr_wdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic rsp_tlast;

   median_window_filter_unit uut (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast
   );

   // predictor state
   logic [7:0] img_rows [LROWS][MAXW];
   int unsigned cfg_width = 1024, cfg_height = 1024, cfg_window = 3;
   int unsigned in_r, in_c, out_r, out_c;

   req_item_type pending_items[$];
   rsp_item_type expected_pixels[$];
   int items_queued = 0;
   int errors = 0;
   bit idle_enable = 1'b1;
   bit long_holdoff = 1'b0;
   int watchdog = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void restart_positions();
      in_r = 0; in_c = 0; out_r = 0; out_c = 0;
   endfunction

   function automatic void push_item(logic mode, logic [7:0] pixel);
      pending_items.push_back('{mode: mode, pixel: pixel});
      items_queued++;
   endfunction

   function automatic logic [7:0] window_median(int r, int c, int w, int h, int a);
      logic [7:0] vals[$];
      int half;
      half = a / 2;
      for (int m = 0; m < a; m++) begin
         for (int n = 0; n < a; n++) begin
            int rr, cc;
            rr = r - half + m;
            cc = c - half + n;
            if (rr >= 0 && rr < h && cc >= 0 && cc < w)
               vals.push_back(img_rows[rr % LROWS][cc]);
         end
      end
      if (vals.size() == 0) return 8'd0;
      vals.sort();
      return vals[vals.size() / 2];
   endfunction

   // advances the predictor by one accepted transaction
   function automatic void predict_median(req_item_type it);
      int unsigned w, h, a, d, rr, cc;
      rsp_item_type res;
      w = cfg_width < 1 ? 1 : (cfg_width > MAXW ? MAXW : cfg_width);
      h = cfg_height < 1 ? 1 : cfg_height;
      a = cfg_window < 1 ? 1 : (cfg_window > MAXA ? MAXA : cfg_window);
      d = a - 1 - a / 2;
      if (it.mode == mwf_pkg::MODE_PIXEL && in_r < h) begin
         img_rows[in_r % LROWS][in_c] = it.pixel;
         in_c++;
         if (in_c >= w) begin
            in_c = 0;
            in_r++;
         end
      end
      if (out_r >= h || out_c >= w) return;
      rr = out_r + d;
      if (rr > h - 1) rr = h - 1;
      cc = out_c + d;
      if (cc > w - 1) cc = w - 1;
      if (!(in_r > rr || (in_r == rr && in_c > cc))) return;
      res.value = window_median(out_r, out_c, w, h, a);
      res.last = (out_r == h - 1 && out_c == w - 1);
      expected_pixels.push_back(res);
      out_c++;
      if (out_c >= w) begin
         out_c = 0;
         out_r++;
      end
      if (res.last) restart_positions();
   endfunction

   // driver
   int src_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_median('{mode: req_tuser, pixel: req_tdata});
            void'(pending_items.pop_front());
         end
         if (req_tvalid && !req_tready) begin
            // hold the offered transaction
         end else if (src_gap > 0) begin
            src_gap <= src_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata <= pending_items[0].pixel;
            req_tuser <= pending_items[0].mode;
            if (idle_enable && $urandom_range(0, 9) == 0)
               src_gap <= $urandom_range(1, 14);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor and receiver stalls
   int sink_gap = 0;
   int holdoff_count = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected result value=%0d last=%0b", $time, rsp_tdata,
                        rsp_tlast);
               errors++;
            end else begin
               rsp_item_type e;
               e = expected_pixels.pop_front();
               if (e.value !== rsp_tdata)
                  $display("%0t: filtered_pixel expected %0d actual %0d", $time,
                           e.value, rsp_tdata);
               if (e.last !== rsp_tlast)
                  $display("%0t: last_of_frame expected %0b actual %0b", $time,
                           e.last, rsp_tlast);
               if (e.value !== rsp_tdata || e.last !== rsp_tlast) errors++;
            end
         end
         if (long_holdoff && holdoff_count < 400) begin
            holdoff_count <= holdoff_count + 1;
            rsp_tready <= 1'b0;
         end else if (sink_gap > 0) begin
            sink_gap <= sink_gap - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (idle_enable && $urandom_range(0, 9) == 0)
               sink_gap <= $urandom_range(1, 14);
         end
      end
   end

   // watchdog on accepted transactions
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         watchdog <= 0;
      else if (pending_items.size() > 0 || expected_pixels.size() > 0)
         watchdog <= watchdog + 1;
      if (watchdog >= WATCHDOG_LIMIT) begin
         $display("tb_median_window_filter_unit: done, errors");
         $finish;
      end
   end

   task automatic write_csr(mwf_pkg::csr_index_type idx, int unsigned val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[mwf_pkg::CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         mwf_pkg::CSR_IMAGE_WIDTH: cfg_width = val & 11'h7FF;
         mwf_pkg::CSR_IMAGE_HEIGHT: cfg_height = val & 16'hFFFF;
         default: cfg_window = val & 3'h7;
      endcase
      restart_positions();
   endtask

   task automatic wait_quiet();
      while (!(pending_items.size() == 0 && !req_tvalid && expected_pixels.size() == 0))
         @(posedge clock);
      // a drain that yields nothing may still be in flight
      repeat (120) @(posedge clock);
   endtask

   task automatic setup(int unsigned w, int unsigned h, int unsigned a);
      wait_quiet();
      write_csr(mwf_pkg::CSR_IMAGE_WIDTH, w);
      write_csr(mwf_pkg::CSR_IMAGE_HEIGHT, h);
      write_csr(mwf_pkg::CSR_WINDOW_SIZE, a);
   endtask

   // one frame of random pixels, enough drains to flush it, and now and then noise
   task automatic queue_frame(int unsigned w, int unsigned h, int unsigned a, int noise);
      int wc, hc, ac, dd, lag;
      wc = w < 1 ? 1 : (w > MAXW ? MAXW : w);
      hc = h < 1 ? 1 : h;
      ac = a < 1 ? 1 : (a > MAXA ? MAXA : a);
      dd = ac - 1 - ac / 2;
      lag = (dd < hc - 1) ? dd : hc - 1;
      for (int i = 0; i < wc * hc; i++) begin
         if (noise && $urandom_range(0, 19) == 0)
            push_item(mwf_pkg::MODE_DRAIN, 8'($urandom));
         push_item(mwf_pkg::MODE_PIXEL, 8'($urandom));
      end
      if (noise && $urandom_range(0, 1))
         push_item(mwf_pkg::MODE_PIXEL, 8'($urandom));
      for (int i = 0; i < lag * (wc + 1) + dd + 2; i++)
         push_item(mwf_pkg::MODE_DRAIN, 8'($urandom));
   endtask

   initial begin
      int unsigned w, h, a;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // directed: extremes of pixel values, smallest image, window corner cases
      setup(3, 2, 3);
      push_item(mwf_pkg::MODE_DRAIN, 8'hFF);
      push_item(mwf_pkg::MODE_PIXEL, 8'h00);
      push_item(mwf_pkg::MODE_PIXEL, 8'hFF);
      push_item(mwf_pkg::MODE_PIXEL, 8'h55);
      push_item(mwf_pkg::MODE_PIXEL, 8'hAA);
      push_item(mwf_pkg::MODE_PIXEL, 8'h01);
      push_item(mwf_pkg::MODE_PIXEL, 8'h80);
      push_item(mwf_pkg::MODE_PIXEL, 8'h7F);
      repeat (8) push_item(mwf_pkg::MODE_DRAIN, 8'h00);
      setup(0, 0, 0);
      queue_frame(1, 1, 1, 0);
      setup(1, 3, 7);
      queue_frame(1, 3, 7, 0);
      setup(2, 2, 4);
      queue_frame(2, 2, 4, 0);
      // out of range width clamp, largest window
      setup(2047, 1, 7);
      queue_frame(2047, 1, 7, 0);
      setup(5, 65535, 2);
      for (int i = 0; i < 15; i++)
         push_item(mwf_pkg::MODE_PIXEL, 8'($urandom));
      long_holdoff = 1'b1;
      // register write mid frame restarts it
      setup(4, 3, 5);
      queue_frame(4, 3, 5, 1);
      while (items_queued < ITEM_BUDGET) begin
         if ($urandom_range(0, 9) == 0) begin
            w = $urandom_range(20, 40);
            h = $urandom_range(1, 2);
         end else begin
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 6);
         end
         a = $urandom_range(0, 7);
         if (items_queued > QUIET_TAIL) idle_enable = 1'b0;
         setup(w, h, a);
         queue_frame(w, h, a, 1);
      end
      wait_quiet();
      if (errors == 0) begin
         $display("tb_median_window_filter_unit: done, clean");
      end else begin
         $display("tb_median_window_filter_unit: done, errors");
      end
      $finish;
   end

endmodule

`default_nettype wire
